// File: rtl/vmt_pkg.sv
// shared types, constants and stage-enable struct for the 4x4 transform engine
package vmt_pkg;

    localparam int WORD_W        = 32;
    localparam int MAT_DIM       = 4;
    localparam int MAT_ENTRIES   = MAT_DIM * MAT_DIM;
    localparam int IDX_W         = 2;
    localparam int FRAC_BITS_DEF = 16;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic [IDX_W-1:0]         idx_t;

    localparam word_t WORD_MAX = 32'sh7FFF_FFFF;
    localparam word_t WORD_MIN = 32'sh8000_0000;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_XFORM = 1'b1;

    // per-stage load enables of the arithmetic pipeline
    typedef struct packed {
        logic mul_en;
        logic pair_en;
        logic sum_en;
    } stage_en_t;

endpackage

// File: rtl/vmt_matrix_store.sv
// 4x4 coefficient store, one write port, all entries visible at once
module vmt_matrix_store
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  vmt_pkg::idx_t wr_row,
    input  vmt_pkg::idx_t wr_col,
    input  vmt_pkg::word_t wr_data,
    output vmt_pkg::word_t coef [vmt_pkg::MAT_ENTRIES]
);

    vmt_pkg::word_t coef_reg [vmt_pkg::MAT_ENTRIES];
    logic [2*vmt_pkg::IDX_W-1:0] wr_idx;

    assign wr_idx = {wr_row, wr_col};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < vmt_pkg::MAT_ENTRIES; i++)
            begin
                coef_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            coef_reg[wr_idx] <= wr_data;
        end
    end

    assign coef = coef_reg;

endmodule

// File: rtl/vmt_row_dot.sv
// one matrix row: four products, pair sums, final sum with shift and saturation
module vmt_row_dot
#(
    parameter int FRAC_BITS = vmt_pkg::FRAC_BITS_DEF
)
(
    input  logic               clk,
    input  vmt_pkg::stage_en_t en,
    input  vmt_pkg::word_t     coef [vmt_pkg::MAT_DIM],
    input  vmt_pkg::word_t     vec  [vmt_pkg::MAT_DIM],
    output vmt_pkg::word_t     result,
    output logic               sat
);

    localparam int PROD_W = 2 * vmt_pkg::WORD_W;
    localparam int PAIR_W = PROD_W + 1;
    localparam int SUM_W  = PROD_W + 2;

    localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(vmt_pkg::WORD_MAX);
    localparam logic signed [SUM_W-1:0] SUM_MIN = SUM_W'(vmt_pkg::WORD_MIN);

    logic signed [PROD_W-1:0] prod_reg [vmt_pkg::MAT_DIM];
    logic signed [PROD_W-1:0] prod_next [vmt_pkg::MAT_DIM];
    logic signed [PAIR_W-1:0] pair_reg [2];
    logic signed [PAIR_W-1:0] pair_next [2];
    logic signed [SUM_W-1:0]  sum;
    logic signed [SUM_W-1:0]  shifted;
    vmt_pkg::word_t           result_reg;
    vmt_pkg::word_t           result_next;
    logic                     sat_reg;
    logic                     sat_next;

    // full-width signed products
    always_comb
    begin
        for (int k = 0; k < vmt_pkg::MAT_DIM; k++)
        begin
            prod_next[k] = PROD_W'(coef[k]) * PROD_W'(vec[k]);
        end
    end

    always_comb
    begin
        pair_next[0] = PAIR_W'(prod_reg[0]) + PAIR_W'(prod_reg[1]);
        pair_next[1] = PAIR_W'(prod_reg[2]) + PAIR_W'(prod_reg[3]);
    end

    // exact sum, floor shift, clamp to word range
    always_comb
    begin
        sum     = SUM_W'(pair_reg[0]) + SUM_W'(pair_reg[1]);
        shifted = sum >>> FRAC_BITS;
        if (shifted > SUM_MAX)
        begin
            result_next = vmt_pkg::WORD_MAX;
            sat_next    = 1'b1;
        end
        else if (shifted < SUM_MIN)
        begin
            result_next = vmt_pkg::WORD_MIN;
            sat_next    = 1'b1;
        end
        else
        begin
            result_next = shifted[vmt_pkg::WORD_W-1:0];
            sat_next    = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.mul_en)
        begin
            prod_reg <= prod_next;
        end
        if (en.pair_en)
        begin
            pair_reg <= pair_next;
        end
        if (en.sum_en)
        begin
            result_reg <= result_next;
            sat_reg    <= sat_next;
        end
    end

    assign result = result_reg;
    assign sat    = sat_reg;

endmodule

// File: rtl/vec4_matrix_transform.sv
// 4x4 homogeneous matrix-vector transform engine, top level
// a transform transfer passes the product, pair-sum and result registers before its result is offered
// one item per cycle while the result side does not stall, loads and transforms mixed freely
// a load takes effect for every transform accepted after it, and gives no result
// rate is set by one 32x32 multiplier per coefficient, sixteen working in parallel
// reset clears the matrix to zero and empties the pipeline
module vec4_matrix_transform
#(
    parameter int FRAC_BITS = vmt_pkg::FRAC_BITS_DEF
)
(
    input  logic           clk,
    input  logic           rst_n,
    // input channel
    input  logic           item_valid,
    output logic           item_stall,
    input  logic           mode,
    input  vmt_pkg::idx_t  coef_row,
    input  vmt_pkg::idx_t  coef_col,
    input  vmt_pkg::word_t coef_value,
    input  vmt_pkg::word_t vec_x,
    input  vmt_pkg::word_t vec_y,
    input  vmt_pkg::word_t vec_z,
    input  vmt_pkg::word_t vec_w,
    // result channel
    output logic           result_valid,
    input  logic           result_stall,
    output vmt_pkg::word_t out_x,
    output vmt_pkg::word_t out_y,
    output vmt_pkg::word_t out_z,
    output vmt_pkg::word_t out_w,
    output logic           overflow
);

    // pipeline occupancy: products, pair sums, result register
    logic mul_valid_reg;
    logic mul_valid_next;
    logic pair_valid_reg;
    logic pair_valid_next;
    logic res_valid_reg;
    logic res_valid_next;

    logic en_mul;
    logic en_pair;
    logic en_res;
    logic accept;
    logic load_acc;
    logic xform_acc;

    vmt_pkg::stage_en_t en;
    vmt_pkg::word_t     coef [vmt_pkg::MAT_ENTRIES];
    vmt_pkg::word_t     vec  [vmt_pkg::MAT_DIM];
    vmt_pkg::word_t     row_res [vmt_pkg::MAT_DIM];
    logic [vmt_pkg::MAT_DIM-1:0] row_sat;

    // a stage moves on when it is empty or the stage after it moves on
    assign en_res  = !res_valid_reg || !result_stall;
    assign en_pair = !pair_valid_reg || en_res;
    assign en_mul  = !mul_valid_reg || en_pair;

    assign item_stall = !en_mul;
    assign accept     = item_valid && en_mul;
    assign load_acc   = accept && (mode == vmt_pkg::MODE_LOAD);
    assign xform_acc  = accept && (mode == vmt_pkg::MODE_XFORM);

    assign en.mul_en  = en_mul;
    assign en.pair_en = en_pair;
    assign en.sum_en  = en_res;

    always_comb
    begin
        mul_valid_next  = en_mul  ? xform_acc      : mul_valid_reg;
        pair_valid_next = en_pair ? mul_valid_reg  : pair_valid_reg;
        res_valid_next  = en_res  ? pair_valid_reg : res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg  <= 1'b0;
            pair_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            mul_valid_reg  <= mul_valid_next;
            pair_valid_reg <= pair_valid_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    // coefficient store, written on a load transfer; a transform samples it
    // into its product registers at acceptance, so later loads cannot disturb it
    vmt_matrix_store u_store
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (load_acc),
        .wr_row  (coef_row),
        .wr_col  (coef_col),
        .wr_data (coef_value),
        .coef    (coef)
    );

    assign vec[0] = vec_x;
    assign vec[1] = vec_y;
    assign vec[2] = vec_z;
    assign vec[3] = vec_w;

    // one dot-product unit per matrix row
    for (genvar r = 0; r < vmt_pkg::MAT_DIM; r++)
    begin : g_row
        vmt_pkg::word_t row_coef [vmt_pkg::MAT_DIM];

        for (genvar c = 0; c < vmt_pkg::MAT_DIM; c++)
        begin : g_col
            assign row_coef[c] = coef[r * vmt_pkg::MAT_DIM + c];
        end

        vmt_row_dot #(.FRAC_BITS(FRAC_BITS)) u_row
        (
            .clk    (clk),
            .en     (en),
            .coef   (row_coef),
            .vec    (vec),
            .result (row_res[r]),
            .sat    (row_sat[r])
        );
    end

    assign result_valid = res_valid_reg;
    assign out_x        = row_res[0];
    assign out_y        = row_res[1];
    assign out_z        = row_res[2];
    assign out_w        = row_res[3];
    assign overflow     = |row_sat;

endmodule

// File: tb/tb.sv
// self-checking testbench for the 4x4 matrix-vector transform engine
module tb;

    // pipeline depth of a transform transfer: product, pair-sum and result registers
    localparam int             LATENCY   = 3;
    // length of the single long result hold-off, in cycles
    localparam int             LONG_HOLD = 60;
    // 1.0 in q16.16
    localparam vmt_pkg::word_t ONE_Q16   = 32'sh0001_0000;

    // bounds of a signed 32-bit word, held at the width of the exact row sum
    localparam logic signed [65:0] SUM_HI = 66'sd2147483647;
    localparam logic signed [65:0] SUM_LO = -66'sd2147483648;

    // one predicted result transfer
    typedef struct packed {
        vmt_pkg::word_t x;
        vmt_pkg::word_t y;
        vmt_pkg::word_t z;
        vmt_pkg::word_t w;
        logic           ovf;
    } vec_result_t;

    // holds a copy of the coefficient store, predicts each transform and
    // checks result transfers in order
    class xform_scoreboard;
        vmt_pkg::word_t coef_mem [vmt_pkg::MAT_ENTRIES];
        vec_result_t    pending_results [$];
        int unsigned    loads_seen;
        int unsigned    xforms_seen;
        int unsigned    results_checked;
        int unsigned    saturated_results;
        int unsigned    mismatches;

        function new();
            foreach (coef_mem[i])
            begin
                coef_mem[i] = '0;
            end
            loads_seen        = 0;
            xforms_seen       = 0;
            results_checked   = 0;
            saturated_results = 0;
            mismatches        = 0;
        endfunction

        function int unsigned outstanding();
            return pending_results.size();
        endfunction

        // called for every accepted input transfer
        function void note_transfer(logic m, vmt_pkg::idx_t r, vmt_pkg::idx_t c,
                                    vmt_pkg::word_t cv, vmt_pkg::word_t x,
                                    vmt_pkg::word_t y, vmt_pkg::word_t z,
                                    vmt_pkg::word_t w);
            vmt_pkg::word_t     vec [vmt_pkg::MAT_DIM];
            vmt_pkg::word_t     comp [vmt_pkg::MAT_DIM];
            logic signed [65:0] dot_sum;
            logic signed [65:0] scaled;
            logic               clipped;
            if (m == vmt_pkg::MODE_LOAD)
            begin
                coef_mem[int'(r) * vmt_pkg::MAT_DIM + int'(c)] = cv;
                loads_seen++;
                return;
            end
            vec[0]  = x;
            vec[1]  = y;
            vec[2]  = z;
            vec[3]  = w;
            clipped = 1'b0;
            for (int row = 0; row < vmt_pkg::MAT_DIM; row++)
            begin
                // full-width products, summed exactly, then floor shift
                dot_sum = '0;
                for (int k = 0; k < vmt_pkg::MAT_DIM; k++)
                begin
                    dot_sum = dot_sum + coef_mem[row * vmt_pkg::MAT_DIM + k] * vec[k];
                end
                scaled = dot_sum >>> vmt_pkg::FRAC_BITS_DEF;
                if (scaled > SUM_HI)
                begin
                    comp[row] = vmt_pkg::WORD_MAX;
                    clipped   = 1'b1;
                end
                else if (scaled < SUM_LO)
                begin
                    comp[row] = vmt_pkg::WORD_MIN;
                    clipped   = 1'b1;
                end
                else
                begin
                    comp[row] = scaled[vmt_pkg::WORD_W-1:0];
                end
            end
            pending_results.push_back('{comp[0], comp[1], comp[2], comp[3], clipped});
            xforms_seen++;
            if (clipped)
            begin
                saturated_results++;
            end
        endfunction

        // called for every accepted result transfer
        function void check_result(vmt_pkg::word_t x, vmt_pkg::word_t y,
                                   vmt_pkg::word_t z, vmt_pkg::word_t w, logic ovf);
            vec_result_t want;
            if (pending_results.size() == 0)
            begin
                if (mismatches < 10)
                begin
                    $write("tb: result transfer with nothing outstanding: ");
                    $display("x=%h y=%h z=%h w=%h ovf=%b", x, y, z, w, ovf);
                end
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            results_checked++;
            if (x !== want.x || y !== want.y || z !== want.z || w !== want.w
                || ovf !== want.ovf)
            begin
                if (mismatches < 10)
                begin
                    $write("tb: mismatch on result %0d: want x=%h y=%h z=%h w=%h ovf=%b, ",
                           results_checked, want.x, want.y, want.z, want.w, want.ovf);
                    $display("got x=%h y=%h z=%h w=%h ovf=%b", x, y, z, w, ovf);
                end
                mismatches++;
            end
        endfunction
    endclass

    logic           clk;
    logic           rst_n;
    logic           item_valid;
    logic           item_stall;
    logic           mode;
    vmt_pkg::idx_t  coef_row;
    vmt_pkg::idx_t  coef_col;
    vmt_pkg::word_t coef_value;
    vmt_pkg::word_t vec_x;
    vmt_pkg::word_t vec_y;
    vmt_pkg::word_t vec_z;
    vmt_pkg::word_t vec_w;
    logic           result_valid;
    logic           result_stall;
    vmt_pkg::word_t out_x;
    vmt_pkg::word_t out_y;
    vmt_pkg::word_t out_z;
    vmt_pkg::word_t out_w;
    logic           overflow;

    xform_scoreboard sb;

    // calm switches off random idling on both sides for the tail of the run
    bit          calm          = 1'b0;
    // bumped by the stimulus to ask the result side for one long hold-off
    int unsigned hold_off_reqs = 0;

    vec4_matrix_transform u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .mode         (mode),
        .coef_row     (coef_row),
        .coef_col     (coef_col),
        .coef_value   (coef_value),
        .vec_x        (vec_x),
        .vec_y        (vec_y),
        .vec_z        (vec_z),
        .vec_w        (vec_w),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .out_x        (out_x),
        .out_y        (out_y),
        .out_z        (out_z),
        .out_w        (out_w),
        .overflow     (overflow)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // hard limit on run length, far beyond the slowest correct run
    initial
    begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

    // result side: random stall bursts, plus the single long hold-off whose
    // length is counted here, cycle by cycle
    initial
    begin : result_sink
        int unsigned stall_left;
        int unsigned hold_offs_done;
        stall_left     = 0;
        hold_offs_done = 0;
        result_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
                stall_left--;
            else if (hold_off_reqs != hold_offs_done)
            begin
                stall_left = LONG_HOLD;
                hold_offs_done++;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 4);
            result_stall <= (stall_left != 0);
        end
    end

    // result monitor: values are read before this edge's updates land
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            sb.check_result(out_x, out_y, out_z, out_w, overflow);
    end

    // random q16.16 word; tame values stay within a few units so that sums
    // seldom saturate, the rest span the whole range with the extremes mixed in
    function automatic vmt_pkg::word_t pick_word(bit tame);
        int unsigned    pick;
        vmt_pkg::word_t raw;
        pick = $urandom_range(0, 15);
        raw  = vmt_pkg::word_t'($urandom);
        if (!tame)
        begin
            case (pick)
                0: return vmt_pkg::WORD_MAX;
                1: return vmt_pkg::WORD_MIN;
                2: return '0;
                3: return ONE_Q16;
                default: return raw >>> $urandom_range(0, 24);
            endcase
        end
        return raw >>> $urandom_range(12, 28);
    endfunction

    // offers one transfer and waits for it to be taken; always entered on a
    // rising edge, so valid stays high between back-to-back transfers
    task automatic send_item(logic m, vmt_pkg::idx_t r, vmt_pkg::idx_t c,
                             vmt_pkg::word_t cv, vmt_pkg::word_t x, vmt_pkg::word_t y,
                             vmt_pkg::word_t z, vmt_pkg::word_t w);
        item_valid <= 1'b1;
        mode       <= m;
        coef_row   <= r;
        coef_col   <= c;
        coef_value <= cv;
        vec_x      <= x;
        vec_y      <= y;
        vec_z      <= z;
        vec_w      <= w;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        sb.note_transfer(m, r, c, cv, x, y, z, w);
    endtask

    // coefficient load, vector fields carry junk the block must ignore
    task automatic send_load(vmt_pkg::idx_t r, vmt_pkg::idx_t c, vmt_pkg::word_t cv);
        send_item(vmt_pkg::MODE_LOAD, r, c, cv,
                  vmt_pkg::word_t'($urandom), vmt_pkg::word_t'($urandom),
                  vmt_pkg::word_t'($urandom), vmt_pkg::word_t'($urandom));
    endtask

    // transform, coefficient fields carry junk the block must ignore
    task automatic send_xform(vmt_pkg::word_t x, vmt_pkg::word_t y,
                              vmt_pkg::word_t z, vmt_pkg::word_t w);
        send_item(vmt_pkg::MODE_XFORM, vmt_pkg::idx_t'($urandom),
                  vmt_pkg::idx_t'($urandom), vmt_pkg::word_t'($urandom),
                  x, y, z, w);
    endtask

    // occasional idle burst on the input side
    task automatic sender_gap();
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    // roughly three transforms for every two loads
    task automatic random_item(bit tame);
        sender_gap();
        if ($urandom_range(0, 9) < 4)
            send_load(vmt_pkg::idx_t'($urandom_range(0, 3)),
                      vmt_pkg::idx_t'($urandom_range(0, 3)), pick_word(tame));
        else
            send_xform(pick_word(tame), pick_word(tame), pick_word(tame), pick_word(tame));
    endtask

    // stop offering until every outstanding result has arrived, then let the
    // pipeline run dry
    task automatic wait_drained();
        item_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    initial
    begin
        sb = new();
        rst_n      <= 1'b0;
        item_valid <= 1'b0;
        mode       <= vmt_pkg::MODE_LOAD;
        coef_row   <= '0;
        coef_col   <= '0;
        coef_value <= '0;
        vec_x      <= '0;
        vec_y      <= '0;
        vec_z      <= '0;
        vec_w      <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // matrix is all zero after reset, so even extreme inputs give zero
        send_xform(vmt_pkg::WORD_MAX, vmt_pkg::WORD_MIN, -32'sd1, 32'sd1);

        // identity matrix passes the vector through unchanged
        for (int i = 0; i < vmt_pkg::MAT_DIM; i++)
        begin
            sender_gap();
            send_load(vmt_pkg::idx_t'(i), vmt_pkg::idx_t'(i), ONE_Q16);
        end
        send_xform(32'sh0001_8000, -32'sh0002_4000, vmt_pkg::WORD_MAX, vmt_pkg::WORD_MIN);

        // tiny coefficient times minus one: the shift floors to minus one
        send_load(2'd0, 2'd0, 32'sd1);
        send_xform(-32'sd1, ONE_Q16, -ONE_Q16, 32'sd7);

        // row one saturates high, row two saturates low, row three is exact
        send_load(2'd1, 2'd1, vmt_pkg::WORD_MAX);
        sender_gap();
        send_load(2'd2, 2'd2, vmt_pkg::WORD_MIN);
        send_xform(-32'sd1, vmt_pkg::WORD_MAX, vmt_pkg::WORD_MAX, vmt_pkg::WORD_MIN);

        // most negative everywhere in row three: the row sum needs every bit
        for (int c = 0; c < vmt_pkg::MAT_DIM; c++)
        begin
            send_load(2'd3, vmt_pkg::idx_t'(c), vmt_pkg::WORD_MIN);
        end
        send_xform(vmt_pkg::WORD_MIN, vmt_pkg::WORD_MIN, vmt_pkg::WORD_MIN,
                   vmt_pkg::WORD_MIN);
        wait_drained();

        // tame matrix and tame vectors first, so results mostly stay in range
        for (int r = 0; r < vmt_pkg::MAT_DIM; r++)
        begin
            for (int c = 0; c < vmt_pkg::MAT_DIM; c++)
            begin
                sender_gap();
                send_load(vmt_pkg::idx_t'(r), vmt_pkg::idx_t'(c), pick_word(1'b1));
            end
        end
        repeat (300) random_item(1'b1);

        // long result hold-off while transforms keep coming back to back, so
        // the pipeline fills and the input side is stalled
        hold_off_reqs++;
        repeat (40)
        begin
            send_xform(pick_word(1'b0), pick_word(1'b0), pick_word(1'b0), pick_word(1'b0));
        end
        wait_drained();

        // full-range values, saturation frequent
        repeat (400) random_item(1'b0);
        wait_drained();

        // no idling on either side from here on
        calm = 1'b1;
        repeat (250) random_item(1'($urandom_range(0, 1)));
        wait_drained();

        $display("tb: %0d coefficient loads, %0d transforms, %0d results checked, %0d saturated",
                 sb.loads_seen, sb.xforms_seen, sb.results_checked, sb.saturated_results);
        $write("tb: covered zero and identity matrices, extreme products, ");
        $display("a long hold-off and a calm tail");
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
